[rtl/efdt_pkg.sv]
// Package for the edge-function fragment depth test block.
// Holds sizes, depth codes, the pipelined divider stage type and helper functions.
// No dependencies.
package efdt_pkg;

  localparam int DEF_SCREEN_WIDTH  = 256;
  localparam int DEF_SCREEN_HEIGHT = 256;

  localparam int AW            = 16;
  localparam int DEPTH_ENTRIES = 1 << AW;
  localparam logic [15:0] DEPTH_FAR = 16'h7FFF;

  // Edge values fit in 28 bits signed for 13-bit coordinates; one spare bit.
  localparam int EW = 29;

  // Divider pipeline: 2 quotient bits per stage.
  localparam int DIV_STAGES  = 8;
  localparam int BYTE_STAGES = 4;

  typedef struct packed {
    logic               v;
    logic               clr;
    logic               frag;
    logic [AW-1:0]      addr;
    logic [7:0]         px;
    logic [7:0]         py;
    logic [EW-1:0]      dd;     // 2*area, depth divisor
    logic [EW-1:0]      ad;     // area, byte divisor
    logic [EW-1:0]      dr;     // depth partial remainder
    logic [15:0]        dl;     // depth numerator bits still to shift in
    logic [15:0]        dq;
    logic [2:0][EW-1:0] br;
    logic [2:0][7:0]    bl;
    logic [2:0][7:0]    bq;
  } div_t;

  function automatic logic signed [13:0] coord_diff(input logic [12:0] a,
                                                    input logic [12:0] b);
    coord_diff = $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

  // One restoring step: returns {quotient bit, new remainder}.
  function automatic logic [EW:0] div_step(input logic [EW-1:0] r,
                                           input logic          b,
                                           input logic [EW-1:0] d);
    logic [EW:0] t;
    logic [EW:0] s;
    t = {r, b};
    s = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      div_step = {1'b1, s[EW-1:0]};
    end else begin
      div_step = {1'b0, t[EW-1:0]};
    end
  endfunction

endpackage

[rtl/edge_function_fragment_depth_test.sv]
// Top level of the edge-function fragment depth test: edge setup, dividers,
// depth store with forwarding, depth-view shading and output register.
// Depends on efdt_pkg.
// Pipeline: one item per cycle sustained while the output is not stalled;
// 16 register stages, with the two-bit-per-stage divider taking 8 of them.
// Depth store: one write port and one registered read port; a write-to-read
// forward covers back-to-back items on the same pixel.
// Reset: synchronous; after rst falls a clearing pass fills all 65536 entries of the
// depth store with farthest depth while in_ready stays low (cfg writes still taken).
module edge_function_fragment_depth_test
  import efdt_pkg::*;
#(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               op,
  input  logic [12:0]        vert_a_x,
  input  logic [12:0]        vert_a_y,
  input  logic signed [15:0] vert_a_z,
  input  logic [12:0]        vert_b_x,
  input  logic [12:0]        vert_b_y,
  input  logic signed [15:0] vert_b_z,
  input  logic [12:0]        vert_c_x,
  input  logic [12:0]        vert_c_y,
  input  logic signed [15:0] vert_c_z,
  input  logic [7:0]         pix_x,
  input  logic [7:0]         pix_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_x,
  output logic [7:0]         out_y,
  output logic [7:0]         byte0,
  output logic [7:0]         byte1,
  output logic [7:0]         byte2,
  output logic [7:0]         byte3
);

  logic depth_view_mode;
  logic adv;
  logic [AW:0] clr_cnt;
  logic clr_done;

  assign cfg_ready = 1'b1;
  assign clr_done  = clr_cnt[AW];
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv && clr_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_view_mode <= 1'b0;
    end else if (cfg_valid) begin
      depth_view_mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (!clr_done) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // ---------------- stage 1: coordinate differences, address
  logic [12:0] qx, qy;
  logic [31:0] lin;
  logic        on_scr;
  logic signed [13:0] dif [0:15];

  assign qx     = {1'b0, pix_x, 4'b0000};
  assign qy     = {1'b0, pix_y, 4'b0000};
  assign lin    = 32'(pix_y) * 32'(SCREEN_WIDTH) + 32'(pix_x);
  assign on_scr = (32'(pix_x) < 32'(SCREEN_WIDTH)) && (32'(pix_y) < 32'(SCREEN_HEIGHT));

  always_comb begin
    dif[0]  = coord_diff(vert_c_x, vert_a_x);
    dif[1]  = coord_diff(vert_b_y, vert_a_y);
    dif[2]  = coord_diff(vert_c_y, vert_a_y);
    dif[3]  = coord_diff(vert_b_x, vert_a_x);
    dif[4]  = coord_diff(qx, vert_b_x);
    dif[5]  = coord_diff(vert_c_y, vert_b_y);
    dif[6]  = coord_diff(qy, vert_b_y);
    dif[7]  = coord_diff(vert_c_x, vert_b_x);
    dif[8]  = coord_diff(qx, vert_c_x);
    dif[9]  = coord_diff(vert_a_y, vert_c_y);
    dif[10] = coord_diff(qy, vert_c_y);
    dif[11] = coord_diff(vert_a_x, vert_c_x);
    dif[12] = coord_diff(qx, vert_a_x);
    dif[13] = coord_diff(vert_b_y, vert_a_y);
    dif[14] = coord_diff(qy, vert_a_y);
    dif[15] = coord_diff(vert_b_x, vert_a_x);
  end

  logic               s1_v, s1_op, s1_on;
  logic [AW-1:0]      s1_addr;
  logic [7:0]         s1_px, s1_py;
  logic signed [15:0] s1_z [0:2];
  logic signed [13:0] s1_d [0:15];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv) begin
      s1_v <= in_valid && in_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op   <= op;
      s1_on   <= on_scr;
      s1_addr <= lin[AW-1:0];
      s1_px   <= pix_x;
      s1_py   <= pix_y;
      s1_z[0] <= vert_a_z;
      s1_z[1] <= vert_b_z;
      s1_z[2] <= vert_c_z;
      for (int i = 0; i < 16; i++) begin
        s1_d[i] <= dif[i];
      end
    end
  end

  // ---------------- stage 2: edge products
  logic               s2_v, s2_op, s2_on;
  logic [AW-1:0]      s2_addr;
  logic [7:0]         s2_px, s2_py;
  logic signed [15:0] s2_z [0:2];
  logic signed [27:0] s2_p [0:7];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (adv) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_op   <= s1_op;
      s2_on   <= s1_on;
      s2_addr <= s1_addr;
      s2_px   <= s1_px;
      s2_py   <= s1_py;
      s2_z    <= s1_z;
      for (int j = 0; j < 4; j++) begin
        s2_p[2*j]   <= s1_d[4*j]   * s1_d[4*j+1];
        s2_p[2*j+1] <= s1_d[4*j+2] * s1_d[4*j+3];
      end
    end
  end

  // ---------------- stage 3: area and edge values
  // e[0] is the area, e[1..3] the edges opposite A, B, C.
  logic                 s3_v, s3_op, s3_on;
  logic [AW-1:0]        s3_addr;
  logic [7:0]           s3_px, s3_py;
  logic signed [15:0]   s3_z [0:2];
  logic signed [EW-1:0] s3_e [0:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (adv) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_op   <= s2_op;
      s3_on   <= s2_on;
      s3_addr <= s2_addr;
      s3_px   <= s2_px;
      s3_py   <= s2_py;
      s3_z    <= s2_z;
      for (int j = 0; j < 4; j++) begin
        s3_e[j] <= EW'(s2_p[2*j]) - EW'(s2_p[2*j+1]);
      end
    end
  end

  // ---------------- stage 4: inside test, depth and byte numerators
  logic frag3;
  assign frag3 = !s3_op && s3_on && (s3_e[0] > 0) &&
                 !s3_e[1][EW-1] && !s3_e[2][EW-1] && !s3_e[3][EW-1];

  logic                 s4_v, s4_clr, s4_frag;
  logic [AW-1:0]        s4_addr;
  logic [7:0]           s4_px, s4_py;
  logic signed [EW-1:0] s4_area;
  logic signed [44:0]   s4_zp [0:2];
  logic signed [36:0]   s4_bn [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (adv) begin
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_clr  <= s3_op && s3_on;
      s4_frag <= frag3;
      s4_addr <= s3_addr;
      s4_px   <= s3_px;
      s4_py   <= s3_py;
      s4_area <= s3_e[0];
      for (int j = 0; j < 3; j++) begin
        s4_zp[j] <= s3_z[j] * s3_e[j+1];
        s4_bn[j] <= (37'(s3_e[j+1]) <<< 8) - 37'(s3_e[j+1]);
      end
    end
  end

  // ---------------- divider pipeline
  // Depth: floor((2*num + area) / (2*area)), biased by 32768 so the
  // numerator stays non-negative: N = 2*num + 65537*area.
  logic signed [49:0] num_sum;
  logic [44:0]        dnum;
  div_t               dv [0:DIV_STAGES];
  div_t               dv_in;

  assign num_sum = (50'(s4_zp[0]) + 50'(s4_zp[1]) + 50'(s4_zp[2])) * 2
                   + (50'(s4_area) <<< 16) + 50'(s4_area);
  assign dnum    = num_sum[44:0];

  always_comb begin
    dv_in      = '0;
    dv_in.v    = s4_v;
    dv_in.clr  = s4_clr;
    dv_in.frag = s4_frag;
    dv_in.addr = s4_addr;
    dv_in.px   = s4_px;
    dv_in.py   = s4_py;
    dv_in.dd   = {s4_area[EW-2:0], 1'b0};
    dv_in.ad   = s4_area;
    dv_in.dr   = dnum[44:16];
    dv_in.dl   = dnum[15:0];
    dv_in.dq   = '0;
    for (int j = 0; j < 3; j++) begin
      dv_in.br[j] = s4_bn[j][36:8];
      dv_in.bl[j] = s4_bn[j][7:0];
      dv_in.bq[j] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0].v <= 1'b0;
    end else if (adv) begin
      dv[0].v <= dv_in.v;
    end
    if (adv) begin
      dv[0][$bits(div_t)-2:0] <= dv_in[$bits(div_t)-2:0];
    end
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    div_t nx;
    always_comb begin
      logic [EW:0] s0, s1;
      logic [EW:0] t0 [0:2];
      logic [EW:0] t1 [0:2];
      nx = dv[k];
      s0 = div_step(dv[k].dr, dv[k].dl[15], dv[k].dd);
      s1 = div_step(s0[EW-1:0], dv[k].dl[14], dv[k].dd);
      nx.dr = s1[EW-1:0];
      nx.dl = {dv[k].dl[13:0], 2'b00};
      nx.dq = {dv[k].dq[13:0], s0[EW], s1[EW]};
      for (int j = 0; j < 3; j++) begin
        t0[j] = div_step(dv[k].br[j], dv[k].bl[j][7], dv[k].ad);
        t1[j] = div_step(t0[j][EW-1:0], dv[k].bl[j][6], dv[k].ad);
        if (k < BYTE_STAGES) begin
          nx.br[j] = t1[j][EW-1:0];
          nx.bl[j] = {dv[k].bl[j][5:0], 2'b00};
          nx.bq[j] = {dv[k].bq[j][5:0], t0[j][EW], t1[j][EW]};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1].v <= 1'b0;
      end else if (adv) begin
        dv[k+1].v <= nx.v;
      end
      if (adv) begin
        dv[k+1][$bits(div_t)-2:0] <= nx[$bits(div_t)-2:0];
      end
    end
  end

  // ---------------- depth store, test and write (last divider stage)
  logic [15:0]        mem [0:DEPTH_ENTRIES-1];
  logic [15:0]        rdata;
  logic               fwd_hit;
  logic [15:0]        fwd_data;
  div_t               m;
  logic signed [15:0] m_depth, m_stored;
  logic               m_pass, m_we;
  logic [15:0]        m_wdata;

  assign m        = dv[DIV_STAGES];
  assign m_depth  = {~m.dq[15], m.dq[14:0]};
  assign m_stored = fwd_hit ? fwd_data : rdata;
  assign m_pass   = m_depth < m_stored;
  assign m_we     = m.v && (m.clr || (m.frag && m_pass));
  assign m_wdata  = m.clr ? DEPTH_FAR : m_depth;

  always_ff @(posedge clk) begin
    if (!clr_done) begin
      mem[clr_cnt[AW-1:0]] <= DEPTH_FAR;
    end else if (adv && m_we) begin
      mem[m.addr] <= m_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rdata <= mem[dv[DIV_STAGES-1].addr];
    end
  end

  // The item entering the test stage read the store in the same cycle the
  // previous item wrote it.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (adv) begin
      fwd_hit <= m_we && (m.addr == dv[DIV_STAGES-1].addr);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fwd_data <= m_wdata;
    end
  end

  // ---------------- shade stage 1: depth squared
  logic               t1_v, t1_res, t1_pos;
  logic [7:0]         t1_px, t1_py;
  logic [2:0][7:0]    t1_b;
  logic [14:0]        t1_d;
  logic [29:0]        t1_d2;

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_v <= 1'b0;
    end else if (adv) begin
      t1_v <= m.v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_res <= m.frag && m_pass;
      t1_pos <= m_depth > 0;
      t1_px  <= m.px;
      t1_py  <= m.py;
      t1_b   <= m.bq;
      t1_d   <= m_depth[14:0];
      t1_d2  <= m_depth[14:0] * m_depth[14:0];
    end
  end

  // ---------------- shade stage 2: depth cubed
  logic               t2_v, t2_res, t2_pos;
  logic [7:0]         t2_px, t2_py;
  logic [2:0][7:0]    t2_b;
  logic [44:0]        t2_d3;

  always_ff @(posedge clk) begin
    if (rst) begin
      t2_v <= 1'b0;
    end else if (adv) begin
      t2_v <= t1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t2_res <= t1_res;
      t2_pos <= t1_pos;
      t2_px  <= t1_px;
      t2_py  <= t1_py;
      t2_b   <= t1_b;
      t2_d3  <= t1_d2 * t1_d;
    end
  end

  // ---------------- output register
  logic [53:0] g_full;
  logic [11:0] g_hi;
  logic [7:0]  grey;

  assign g_full = {t2_d3, 9'b0} - {8'b0, t2_d3, 1'b0};
  assign g_hi   = g_full[53:42];
  assign grey   = !t2_pos ? 8'd0 : ((g_hi > 12'd255) ? 8'd255 : g_hi[7:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= t2_v && t2_res;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x <= t2_px;
      out_y <= t2_py;
      if (depth_view_mode) begin
        byte0 <= grey;
        byte1 <= grey;
        byte2 <= grey;
        byte3 <= grey;
      end else begin
        byte0 <= t2_b[0];
        byte1 <= t2_b[1];
        byte2 <= t2_b[2];
        byte3 <= 8'd0;
      end
    end
  end

  // ---------------- assertions
  a_no_input_while_clearing: assert property (@(posedge clk) disable iff (rst)
    !clr_done |-> !in_ready)
    else $error("input accepted during depth store clear");

  a_pipe_empty_while_clearing: assert property (@(posedge clk) disable iff (rst)
    !clr_done |-> !m.v && !t1_v && !out_valid)
    else $error("item in flight during depth store clear");

  // fwd_hit holds through a stall, so only a cycle that advanced needs a write
  a_fwd_only_after_write: assert property (@(posedge clk) disable iff (rst)
    fwd_hit |-> !$past(adv) || $past(m_we))
    else $error("forward hit without preceding write");

  a_grey_bytes_equal: assert property (@(posedge clk) disable iff (rst)
    out_valid && depth_view_mode |-> byte0 == byte1 && byte1 == byte2 && byte2 == byte3)
    else $error("depth view bytes differ");

  a_byte3_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !depth_view_mode |-> byte3 == 8'd0)
    else $error("fourth byte nonzero outside depth view");

endmodule

[verif/edge_function_fragment_depth_test_test.sv]
// Testbench for edge_function_fragment_depth_test: random and directed fragments,
// a shadow depth store and shading predictor, in-order result check.
// Depends on efdt_pkg and the RTL top level.
`timescale 1ns / 100ps

module edge_function_fragment_depth_test_test
  import efdt_pkg::*;
();

  localparam int DRAIN_WAIT = 40;
  localparam int WATCHDOG   = 300000;
  localparam logic OP_SHADE = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef struct {
    logic               op;
    logic [12:0]        ax, ay, bx, by, cx, cy;
    logic signed [15:0] az, bz, cz;
    logic [7:0]         px, py;
  } frag_t;

  typedef struct {
    logic [7:0] x, y, b0, b1, b2, b3;
  } pixel_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic cfg_data = 0;
  logic in_valid = 0;
  logic op = 0;
  logic [12:0] vert_a_x = 0, vert_a_y = 0, vert_b_x = 0, vert_b_y = 0;
  logic [12:0] vert_c_x = 0, vert_c_y = 0;
  logic signed [15:0] vert_a_z = 0, vert_b_z = 0, vert_c_z = 0;
  logic [7:0] pix_x = 0, pix_y = 0;
  logic out_ready = 0;
  logic cfg_ready, in_ready, out_valid;
  logic [7:0] out_x, out_y, byte0, byte1, byte2, byte3;

  edge_function_fragment_depth_test i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .op(op),
    .vert_a_x(vert_a_x), .vert_a_y(vert_a_y), .vert_a_z(vert_a_z),
    .vert_b_x(vert_b_x), .vert_b_y(vert_b_y), .vert_b_z(vert_b_z),
    .vert_c_x(vert_c_x), .vert_c_y(vert_c_y), .vert_c_z(vert_c_z),
    .pix_x(pix_x), .pix_y(pix_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_x(out_x), .out_y(out_y),
    .byte0(byte0), .byte1(byte1), .byte2(byte2), .byte3(byte3)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  logic [15:0] shadow_depth [DEPTH_ENTRIES];
  logic        grey_mode;
  pixel_t      pending_pixels [$];
  int          errors = 0;
  int          burst_left = 0;
  longint      cyc = 0;
  int          quiet = 0;
  frag_t       last_frag;

  function automatic longint edge_fn(longint ax, longint ay, longint bx, longint by,
                                     longint qx, longint qy);
    return (qx - ax) * (by - ay) - (qy - ay) * (bx - ax);
  endfunction

  // Updates the shadow store; returns 1 when the fragment produces a pixel.
  function automatic bit shade_fragment(input frag_t f, output pixel_t r);
    longint area, e1, e2, e3, num, n2, d2, dep, stored;
    longint qx, qy;
    longint unsigned g;
    int idx;
    r = '{default: 0};
    qx = longint'(f.px) << 4;
    qy = longint'(f.py) << 4;
    idx = int'(f.py) * DEF_SCREEN_WIDTH + int'(f.px);
    if (f.op == OP_CLEAR) begin
      shadow_depth[idx] = DEPTH_FAR;
      return 0;
    end
    area = edge_fn(f.ax, f.ay, f.bx, f.by, f.cx, f.cy);
    if (area <= 0) return 0;
    e1 = edge_fn(f.bx, f.by, f.cx, f.cy, qx, qy);
    e2 = edge_fn(f.cx, f.cy, f.ax, f.ay, qx, qy);
    e3 = edge_fn(f.ax, f.ay, f.bx, f.by, qx, qy);
    if (e1 < 0 || e2 < 0 || e3 < 0) return 0;
    num = longint'(f.az) * e1 + longint'(f.bz) * e2 + longint'(f.cz) * e3;
    n2 = 2 * num + area;
    d2 = 2 * area;
    dep = (n2 >= 0) ? n2 / d2 : -((-n2 + d2 - 1) / d2);
    if (dep > 32767) dep = 32767;
    if (dep < -32768) dep = -32768;
    stored = longint'($signed(shadow_depth[idx]));
    if (!(dep < stored)) return 0;
    shadow_depth[idx] = dep[15:0];
    r.x = f.px;
    r.y = f.py;
    if (grey_mode) begin
      g = 0;
      if (dep > 0) begin
        g = (510 * longint'(dep) * dep * dep) >> 42;
        if (g > 255) g = 255;
      end
      r.b0 = g[7:0]; r.b1 = g[7:0]; r.b2 = g[7:0]; r.b3 = g[7:0];
    end else begin
      r.b0 = 8'((e1 * 255) / area);
      r.b1 = 8'((e2 * 255) / area);
      r.b2 = 8'((e3 * 255) / area);
      r.b3 = 0;
    end
    return 1;
  endfunction

  // Holds valid until the item is taken; leaves valid high for a following burst.
  task automatic send_frag(input frag_t f);
    pixel_t r;
    in_valid <= 1;
    op <= f.op;
    vert_a_x <= f.ax; vert_a_y <= f.ay; vert_a_z <= f.az;
    vert_b_x <= f.bx; vert_b_y <= f.by; vert_b_z <= f.bz;
    vert_c_x <= f.cx; vert_c_y <= f.cy; vert_c_z <= f.cz;
    pix_x <= f.px; pix_y <= f.py;
    do @(posedge clk); while (!in_ready);
    if (shade_fragment(f, r)) pending_pixels.push_back(r);
    last_frag = f;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      burst_left = $urandom_range(0, 24);
    end
  endtask

  task automatic drain_results();
    in_valid <= 0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    cfg_valid <= 1;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    grey_mode = m;
  endtask

  function automatic logic [12:0] clamp_coord(input int v);
    if (v < 0) return 0;
    if (v > 8191) return 13'h1FFF;
    return 13'(v);
  endfunction

  function automatic frag_t random_frag();
    frag_t f;
    int r, qx, qy;
    logic [12:0] t;
    if ($urandom_range(0, 7) == 0) begin
      f = last_frag;  // same pixel again: exercises the store forward
    end else begin
      f.px = 8'($urandom);
      f.py = 8'($urandom);
    end
    f.op = ($urandom_range(0, 9) == 0) ? OP_CLEAR : OP_SHADE;
    r = ($urandom_range(0, 3) == 0) ? 1024 : $urandom_range(4, 96);
    qx = int'(f.px) << 4;
    qy = int'(f.py) << 4;
    f.ax = clamp_coord(qx + $urandom_range(0, 2 * r) - r);
    f.ay = clamp_coord(qy + $urandom_range(0, 2 * r) - r);
    f.bx = clamp_coord(qx + $urandom_range(0, 2 * r) - r);
    f.by = clamp_coord(qy + $urandom_range(0, 2 * r) - r);
    f.cx = clamp_coord(qx + $urandom_range(0, 2 * r) - r);
    f.cy = clamp_coord(qy + $urandom_range(0, 2 * r) - r);
    if ($urandom_range(0, 15) == 0) begin
      f.ax = 13'($urandom); f.by = 13'($urandom); f.cx = 13'($urandom);
    end
    // mostly front facing; a few culled triangles stay as drawn
    if ($urandom_range(0, 7) != 0 &&
        edge_fn(f.ax, f.ay, f.bx, f.by, f.cx, f.cy) < 0) begin
      t = f.bx; f.bx = f.cx; f.cx = t;
      t = f.by; f.by = f.cy; f.cy = t;
    end
    if ($urandom_range(0, 7) == 0) begin
      f.az = 16'($urandom); f.bz = 16'($urandom); f.cz = 16'($urandom);
    end else begin
      f.az = 16'($urandom_range(0, 32768) - 16384);
      f.bz = 16'($urandom_range(0, 32768) - 16384);
      f.cz = 16'($urandom_range(0, 32768) - 16384);
    end
    return f;
  endfunction

  function automatic frag_t tri_frag(input int ax, ay, bx, by, cx, cy,
                                     input int az, bz, cz, input int px, py);
    frag_t f;
    f.op = OP_SHADE;
    f.ax = 13'(ax); f.ay = 13'(ay); f.bx = 13'(bx); f.by = 13'(by);
    f.cx = 13'(cx); f.cy = 13'(cy);
    f.az = 16'(az); f.bz = 16'(bz); f.cz = 16'(cz);
    f.px = 8'(px); f.py = 8'(py);
    return f;
  endfunction

  task automatic test_corner_pixels();
    // large triangles, pixels at the screen corners and two interior pixels
    send_frag(tri_frag(0, 0, 0, 8191, 8191, 0, 100, 300, 200, 0, 0));
    send_frag(tri_frag(0, 0, 0, 8191, 8191, 0, -16384, 0, 16384, 255, 0));
    send_frag(tri_frag(0, 0, 0, 8191, 8191, 0, 0, 16384, -16384, 0, 255));
    send_frag(tri_frag(0, 8191, 8191, 8191, 8191, 0, 16384, -16384, 16384, 255, 255));
    send_frag(tri_frag(0, 0, 0, 4096, 4096, 0, -32768, -32768, 32767, 100, 100));
    send_frag(tri_frag(0, 0, 0, 4096, 4096, 0, -32768, -32768, -32768, 10, 10));
  endtask

  task automatic test_rejects();
    frag_t f;
    send_frag(tri_frag(0, 0, 4096, 0, 0, 4096, 0, 0, 0, 20, 20));       // back facing
    send_frag(tri_frag(0, 0, 2048, 2048, 4096, 4096, 0, 0, 0, 64, 64)); // zero area
    send_frag(tri_frag(0, 0, 0, 160, 160, 0, 0, 0, 0, 200, 200));       // outside edge
    send_frag(tri_frag(0, 0, 0, 8191, 8191, 0, 16384, 16384, 16384, 0, 0)); // fails depth
    f = tri_frag(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    f.op = OP_CLEAR;
    send_frag(f);                                                        // clear pixel 0,0
    send_frag(tri_frag(0, 0, 0, 8191, 8191, 0, 16000, 16000, 16000, 0, 0));
    send_frag(tri_frag(0, 0, 0, 8191, 8191, 0, 16000, 16000, 16000, 0, 0)); // equal depth
  endtask

  task automatic test_depth_view();
    drain_results();
    write_mode(1);
    send_frag(tri_frag(0, 0, 0, 8191, 8191, 0, -100, -100, -100, 30, 30));
    send_frag(tri_frag(0, 0, 0, 8191, 8191, 0, 0, 0, 0, 31, 30));
    send_frag(tri_frag(0, 0, 0, 8191, 8191, 0, 13000, 13000, 13000, 32, 30));
    send_frag(tri_frag(0, 0, 0, 8191, 8191, 0, 32000, 32000, 32000, 33, 30));
    send_frag(tri_frag(0, 0, 0, 8191, 8191, 0, 8000, 10000, 9000, 34, 30));
    drain_results();
    write_mode(0);
  endtask

  task automatic test_random(input int n, input logic m);
    drain_results();
    write_mode(m);
    repeat (n) send_frag(random_frag());
  endtask

  // Output stall pattern: rotating stretches of full rate, two random stall rates and a periodic stall.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    case ((cyc >> 8) % 4)
      0: out_ready <= 1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 1) != 0);
      default: out_ready <= ((cyc % 11) < 7);
    endcase
  end

  always @(posedge clk) begin
    pixel_t want;
    if (out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected item x=%0d y=%0d", out_x, out_y);
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_x !== want.x) begin
          $error("out_x expected %0d actual %0d", want.x, out_x); errors++;
        end
        if (out_y !== want.y) begin
          $error("out_y expected %0d actual %0d", want.y, out_y); errors++;
        end
        if (byte0 !== want.b0) begin
          $error("byte0 expected %0d actual %0d", want.b0, byte0); errors++;
        end
        if (byte1 !== want.b1) begin
          $error("byte1 expected %0d actual %0d", want.b1, byte1); errors++;
        end
        if (byte2 !== want.b2) begin
          $error("byte2 expected %0d actual %0d", want.b2, byte2); errors++;
        end
        if (byte3 !== want.b3) begin
          $error("byte3 expected %0d actual %0d", want.b3, byte3); errors++;
        end
      end
    end
  end

  // Watchdog; the limit covers the store clearing pass after reset.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG) begin
      $display("timeout with %0d items outstanding", pending_pixels.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    foreach (shadow_depth[i]) shadow_depth[i] = DEPTH_FAR;
    grey_mode = 0;
    last_frag = tri_frag(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    repeat (2) @(posedge clk);
    rst <= 0;
    write_mode(0);
    test_corner_pixels();
    test_rejects();
    test_depth_view();
    test_random(400, 0);
    test_random(300, 1);
    test_random(320, 0);
    drain_results();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/efdt_pkg.sv
rtl/edge_function_fragment_depth_test.sv
verif/edge_function_fragment_depth_test_test.sv
